>>> hw/rtl/tssd_pkg.sv
// Shared types, constants and segment table for the thermometer display encoder.
package tssd_pkg;

  localparam int READING_W = 16;
  localparam int WORD_W    = 30;
  localparam int DIGIT_W   = 7;
  localparam int VALUE_W   = 12;

  localparam logic [READING_W-1:0] READING_MAX = 16'd64000;
  localparam logic signed [VALUE_W-1:0] CELSIUS_BIAS    = 12'sd500;
  localparam logic signed [VALUE_W-1:0] FAHRENHEIT_BIAS = 12'sd320;

  localparam int DEG_C_BIT = 28;
  localparam int DEG_F_BIT = 29;

  // x/5 == (x*13108)>>16 for x < 8192; x/10 == (x*6554)>>16 for x < 2048;
  // x/10 == (x*205)>>11 for x < 128
  localparam logic [13:0] RECIP5   = 14'd13108;
  localparam logic [12:0] RECIP10  = 13'd6554;
  localparam logic [7:0]  RECIP10S = 8'd205;

  typedef struct packed {
    logic                      valid;
    logic                      range_error;
    logic                      fahrenheit;
    logic signed [VALUE_W-1:0] value;
  } fmt_in_t;

  typedef struct packed {
    logic              valid;
    logic              range_error;
    logic [WORD_W-1:0] word;
  } fmt_out_t;

  function automatic logic [DIGIT_W-1:0] seg_pattern(input logic [3:0] digit);
    logic [DIGIT_W-1:0] pat;
    case (digit)
      4'd0:    pat = 7'b1111110;
      4'd1:    pat = 7'b0001100;
      4'd2:    pat = 7'b0110111;
      4'd3:    pat = 7'b0011111;
      4'd4:    pat = 7'b1001101;
      4'd5:    pat = 7'b1011011;
      4'd6:    pat = 7'b1111011;
      4'd7:    pat = 7'b0001110;
      4'd8:    pat = 7'b1111111;
      4'd9:    pat = 7'b1011111;
      default: pat = '0;
    endcase
    return pat;
  endfunction

endpackage

>>> hw/rtl/thermometer_seven_segment_display.sv
// Top level: sensor reading to seven-segment thermometer display word.
// Fully pipelined, six register stages: one transaction is accepted per cycle
// while s_tready is high, and its result passes through the Celsius, Fahrenheit
// multiply/divide and digit-split stages to the master side. The whole pipeline
// advances whenever the output register is empty or being taken, so s_tready
// follows m_tready when the output holds a result. Readings above 64000 give
// range error with a zero word.
module thermometer_seven_segment_display (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] sensor_reading
  input  logic        s_tuser,   // [0] show_fahrenheit
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [29:0] display_word, [31:30] zero
  output logic        m_tuser    // [0] range_error
);

  logic advance;
  assign advance  = !m_tvalid || m_tready;
  assign s_tready = advance;

  // stage 1: range check, Celsius tenths
  logic                               s1_valid;
  logic                               s1_err;
  logic                               s1_fahr;
  logic signed [tssd_pkg::VALUE_W-1:0] s1_t;

  logic signed [tssd_pkg::VALUE_W-1:0] t_next;

  always_comb begin
    t_next = $signed({2'b00, s_tdata[15:6]}) - tssd_pkg::CELSIUS_BIAS
           + $signed({11'd0, s_tdata[5]});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= s_tvalid;
    end
    if (advance) begin
      s1_err  <= (s_tdata > tssd_pkg::READING_MAX);
      s1_fahr <= s_tuser;
      s1_t    <= t_next;
    end
  end

  // stage 2: t*9, sign and magnitude
  logic                                s2_valid;
  logic                                s2_err;
  logic                                s2_fahr;
  logic signed [tssd_pkg::VALUE_W-1:0] s2_t;
  logic                                s2_neg;
  logic [12:0]                         s2_mag;

  logic signed [13:0] p9;

  always_comb begin
    p9 = (14'(s1_t) <<< 3) + 14'(s1_t);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (advance) begin
      s2_valid <= s1_valid;
    end
    if (advance) begin
      s2_err  <= s1_err;
      s2_fahr <= s1_fahr;
      s2_t    <= s1_t;
      s2_neg  <= p9[13];
      s2_mag  <= p9[13] ? 13'(-p9) : 13'(p9);
    end
  end

  // stage 3: truncating /5, Fahrenheit bias, unit select
  tssd_pkg::fmt_in_t s3;

  logic [26:0]                         q5_prod;
  logic [9:0]                          q5;
  logic signed [tssd_pkg::VALUE_W-1:0] f_val;

  always_comb begin
    q5_prod = 27'(s2_mag) * 27'(tssd_pkg::RECIP5);
    q5      = q5_prod[25:16];
    f_val   = s2_neg ? (tssd_pkg::FAHRENHEIT_BIAS - $signed({2'b00, q5}))
                     : (tssd_pkg::FAHRENHEIT_BIAS + $signed({2'b00, q5}));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3.valid <= 1'b0;
    end else if (advance) begin
      s3.valid <= s2_valid;
    end
    if (advance) begin
      s3.range_error <= s2_err;
      s3.fahrenheit  <= s2_fahr;
      s3.value       <= s2_fahr ? f_val : s2_t;
    end
  end

  // stages 4..6
  tssd_pkg::fmt_out_t fo;

  tssd_fmt u_fmt (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .fin     (s3),
    .fout    (fo)
  );

  assign m_tvalid = fo.valid;
  assign m_tdata  = {2'b00, fo.word};
  assign m_tuser  = fo.range_error;

endmodule

>>> hw/rtl/tssd_fmt.sv
// Three-stage formatter: signed tenths value to seven-segment display word.
module tssd_fmt (
  input  logic               clk,
  input  logic               rst,
  input  logic               advance,
  input  tssd_pkg::fmt_in_t  fin,
  output tssd_pkg::fmt_out_t fout
);

  // stage A: sign, magnitude, magnitude/10
  logic        a_valid;
  logic        a_err;
  logic        a_fahr;
  logic        a_neg;
  logic [10:0] a_mag;
  logic [6:0]  a_q1;

  logic [10:0] mag_next;
  logic [23:0] q1_prod;

  always_comb begin
    mag_next = fin.value[tssd_pkg::VALUE_W-1] ? 11'(-fin.value) : 11'(fin.value);
    q1_prod  = 24'(mag_next) * 24'(tssd_pkg::RECIP10);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (advance) begin
      a_valid <= fin.valid;
    end
    if (advance) begin
      a_err  <= fin.range_error;
      a_fahr <= fin.fahrenheit;
      a_neg  <= fin.value[tssd_pkg::VALUE_W-1];
      a_mag  <= mag_next;
      a_q1   <= q1_prod[22:16];
    end
  end

  // stage B: digits
  logic       b_valid;
  logic       b_err;
  logic       b_fahr;
  logic       b_neg;
  logic [3:0] b_tenths;
  logic [3:0] b_ones;
  logic [3:0] b_tens;
  logic       b_hund;

  logic [10:0] q1_x10;
  logic [10:0] tenths_diff;
  logic [14:0] q2_prod;
  logic [3:0]  q2;
  logic [6:0]  q2_x10;
  logic [6:0]  ones_diff;
  logic        q2_big;
  logic [3:0]  tens_next;

  always_comb begin
    q1_x10      = {1'b0, a_q1, 3'b000} + {3'b000, a_q1, 1'b0};
    tenths_diff = a_mag - q1_x10;
    q2_prod     = 15'(a_q1) * 15'(tssd_pkg::RECIP10S);
    q2          = q2_prod[14:11];
    q2_x10      = {q2, 3'b000} + {2'b00, q2, 1'b0};
    ones_diff   = a_q1 - q2_x10;
    q2_big      = (q2 >= 4'd10);
    tens_next   = q2_big ? (q2 - 4'd10) : q2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (advance) begin
      b_valid <= a_valid;
    end
    if (advance) begin
      b_err    <= a_err;
      b_fahr   <= a_fahr;
      b_neg    <= a_neg;
      b_tenths <= tenths_diff[3:0];
      b_ones   <= ones_diff[3:0];
      b_tens   <= tens_next;
      b_hund   <= q2_big;
    end
  end

  // stage C: segment patterns, blanking, minus and unit bits, zero word on range error
  logic [tssd_pkg::WORD_W-1:0] word_next;
  logic                        show_tens;

  always_comb begin
    show_tens = b_hund || (b_tens != 4'd0);
    word_next = '0;
    word_next[6:0]   = tssd_pkg::seg_pattern(b_tenths);
    word_next[13:7]  = tssd_pkg::seg_pattern(b_ones);
    if (show_tens) begin
      word_next[20:14] = tssd_pkg::seg_pattern(b_tens);
    end
    if (b_hund) begin
      word_next[27:21] = tssd_pkg::seg_pattern({3'b000, b_hund});
    end
    if (b_neg) begin
      if (b_hund) begin
        word_next[28] = 1'b1;
      end else if (show_tens) begin
        word_next[21] = 1'b1;
      end else begin
        word_next[14] = 1'b1;
      end
    end
    if (b_fahr) begin
      word_next[tssd_pkg::DEG_F_BIT] = 1'b1;
    end else begin
      word_next[tssd_pkg::DEG_C_BIT] = 1'b1;
    end
    if (b_err) begin
      word_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fout.valid <= 1'b0;
    end else if (advance) begin
      fout.valid <= b_valid;
    end
    if (advance) begin
      fout.range_error <= b_err;
      fout.word        <= word_next;
    end
  end

endmodule
